FILE: rtl/core/skvt_pkg.sv
// ----------------------------------------------------------------------------
// skvt_pkg: shared types and constants of the sorted key/value table
// Request and result structs, command codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package skvt_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int OUT_CNT_W = 7;

	typedef enum logic [1:0] {
		CMD_SET    = 2'd0,
		CMD_LOOKUP = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [63:0]        key_high;
		logic [63:0]        key_low;
		logic signed [31:0] new_version;
		logic [31:0]        new_name_id;
		logic [31:0]        new_reserved;
	} request_t;

	typedef struct packed {
		logic                found;
		logic signed [31:0]  entry_version;
		logic [31:0]         entry_name_id;
		logic [OUT_CNT_W-1:0] entry_count;
		logic                status;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH_RD,
		ST_SEARCH_CMP,
		ST_HIT_RD,
		ST_HIT_CMP,
		ST_SHIFT_RD,
		ST_SHIFT_WR,
		ST_DONE
	} state_t;

	// Controller to datapath.
	typedef struct packed {
		logic load;        // capture request, start search
		logic rd_mid;      // read entry at search midpoint
		logic step;        // apply compare to search bounds
		logic rd_slot;     // read entry at lower bound
		logic check_hit;   // latch hit flag from slot read
		logic prep_shift;  // set up shift pointer
		logic rd_shift;    // read source entry for shift
		logic wr_shift;    // write shifted entry, advance pointer
		logic finish;      // final write / count update, issue result
	} dp_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic search_done;
		logic shift_done;
		logic need_shift;
	} dp_status_t;

endpackage

FILE: rtl/core/skvt_datapath.sv
// ----------------------------------------------------------------------------
// skvt_datapath: entry memory, search bounds, shift pointer and result
// Holds the sorted entries in one memory with registered read data.
// ----------------------------------------------------------------------------
module skvt_datapath
	import skvt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  request_t   req,
	input  dp_cmd_t    cmd,
	output dp_status_t stat,
	output logic       done,
	output result_t    result
);

	localparam int ENT_W = 64 + 64 + 32 + 32 + 32;

	logic [ENT_W-1:0] mem [TABLE_DEPTH];
	logic [ENT_W-1:0] rd_q;
	logic [IDX_W-1:0] rd_addr;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [ENT_W-1:0] wr_data;

	request_t         req_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] lo_q, hi_q, ptr_q;
	logic             hit_q;
	logic [CNT_W-1:0] mid;
	logic [63:0]      rkh, rkl;
	logic             below, key_eq;
	logic             slot_hit;
	logic             done_q;
	result_t          result_q;

	assign mid   = lo_q + ((hi_q - lo_q) >> 1);
	assign rkh   = rd_q[ENT_W-1 -: 64];
	assign rkl   = rd_q[ENT_W-65 -: 64];
	assign below = (rkh != req_q.key_high) ? (rkh < req_q.key_high)
	                                        : (rkl < req_q.key_low);
	assign key_eq = (rkh == req_q.key_high) && (rkl == req_q.key_low);
	// Valid while the read data holds the entry at the lower bound.
	assign slot_hit = (lo_q < count_q) && key_eq;

	always_comb begin
		rd_addr = lo_q[IDX_W-1:0];
		if (cmd.rd_mid) begin
			rd_addr = mid[IDX_W-1:0];
		end else if (cmd.rd_slot) begin
			rd_addr = lo_q[IDX_W-1:0];
		end else if (cmd.rd_shift) begin
			// Insert copies ptr-1 to ptr; remove copies ptr+1 to ptr.
			if (req_q.cmd == CMD_SET) begin
				rd_addr = IDX_W'(ptr_q - CNT_W'(1));
			end else begin
				rd_addr = IDX_W'(ptr_q + CNT_W'(1));
			end
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = ptr_q[IDX_W-1:0];
		wr_data = rd_q;
		if (cmd.wr_shift) begin
			wr_en = 1'b1;
		end else if (cmd.finish && req_q.cmd == CMD_SET
		             && (hit_q || count_q < CNT_W'(TABLE_DEPTH))) begin
			wr_en   = 1'b1;
			wr_addr = lo_q[IDX_W-1:0];
			wr_data = {req_q.key_high, req_q.key_low, req_q.new_version,
			           req_q.new_name_id, req_q.new_reserved};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	assign stat.search_done = (lo_q >= hi_q);
	assign stat.shift_done  = (req_q.cmd == CMD_SET) ? (ptr_q <= lo_q)
	                                                 : (ptr_q + CNT_W'(1) >= count_q);
	assign stat.need_shift  = ((req_q.cmd == CMD_SET) && !slot_hit
	                           && count_q < CNT_W'(TABLE_DEPTH))
	                          || ((req_q.cmd == CMD_REMOVE) && slot_hit);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			lo_q     <= '0;
			hi_q     <= '0;
			ptr_q    <= '0;
			hit_q    <= 1'b0;
			done_q   <= 1'b0;
			result_q <= '0;
		end else begin
			done_q <= cmd.finish;
			if (cmd.load) begin
				lo_q  <= '0;
				hi_q  <= count_q;
				hit_q <= 1'b0;
			end
			if (cmd.step) begin
				if (below) begin
					lo_q <= mid + CNT_W'(1);
				end else begin
					hi_q <= mid;
				end
			end
			if (cmd.check_hit) begin
				hit_q <= slot_hit;
			end
			if (cmd.prep_shift) begin
				ptr_q <= (req_q.cmd == CMD_SET) ? count_q : lo_q;
			end
			if (cmd.wr_shift) begin
				ptr_q <= (req_q.cmd == CMD_SET) ? ptr_q - CNT_W'(1) : ptr_q + CNT_W'(1);
			end
			if (cmd.finish) begin
				logic [CNT_W-1:0] nc;
				result_t          res;
				nc        = count_q;
				res       = '0;
				res.found = hit_q;
				case (req_q.cmd)
					CMD_SET: begin
						if (!hit_q) begin
							if (count_q >= CNT_W'(TABLE_DEPTH)) begin
								res.status = 1'b1;
							end else begin
								nc = count_q + CNT_W'(1);
							end
						end
					end
					CMD_LOOKUP: begin
						res.entry_version = hit_q ? rd_q[95:64] : 32'sh8000_0000;
						res.entry_name_id = hit_q ? rd_q[63:32] : 32'd0;
					end
					CMD_REMOVE: begin
						if (hit_q) begin
							nc = count_q - CNT_W'(1);
						end
					end
					default: begin
						nc = '0;
					end
				endcase
				res.entry_count = OUT_CNT_W'(nc);
				count_q  <= nc;
				result_q <= res;
			end
		end
	end

	assign done   = done_q;
	assign result = result_q;

`ifndef NO_ASSERTIONS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH)) else $error("count above depth");
	a_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		lo_q <= hi_q + CNT_W'(1)) else $error("search bounds crossed");
	a_refuse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && result_q.status |-> result_q.entry_count == OUT_CNT_W'(TABLE_DEPTH))
		else $error("refusal while not full");
`endif

endmodule

FILE: rtl/core/skvt_controller.sv
// ----------------------------------------------------------------------------
// skvt_controller: command sequencer of the sorted key/value table
// Steps search, slot read, shift loop and completion.
// ----------------------------------------------------------------------------
module skvt_controller
	import skvt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  dp_status_t stat,
	output logic       busy,
	output dp_cmd_t    cmd
);

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:       if (start) state_d = ST_SEARCH_RD;
			ST_SEARCH_RD:  state_d = stat.search_done ? ST_HIT_RD : ST_SEARCH_CMP;
			ST_SEARCH_CMP: state_d = ST_SEARCH_RD;
			ST_HIT_RD:     state_d = ST_HIT_CMP;
			ST_HIT_CMP:    state_d = stat.need_shift ? ST_SHIFT_RD : ST_DONE;
			ST_SHIFT_RD:   state_d = stat.shift_done ? ST_DONE : ST_SHIFT_WR;
			ST_SHIFT_WR:   state_d = ST_SHIFT_RD;
			ST_DONE:       state_d = ST_IDLE;
			default:       state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE:       cmd.load = start;
			ST_SEARCH_RD:  cmd.rd_mid = !stat.search_done;
			ST_SEARCH_CMP: cmd.step = 1'b1;
			ST_HIT_RD:     cmd.rd_slot = 1'b1;
			ST_HIT_CMP: begin
				cmd.check_hit  = 1'b1;
				cmd.prep_shift = 1'b1;
				cmd.rd_slot    = 1'b1;
			end
			ST_SHIFT_RD:   cmd.rd_shift = 1'b1;
			ST_SHIFT_WR:   cmd.wr_shift = 1'b1;
			ST_DONE:       cmd.finish = 1'b1;
			default:       cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_one_shift_op: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.rd_shift, cmd.wr_shift, cmd.finish, cmd.step}))
		else $error("conflicting datapath commands");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE |=> state_q == ST_IDLE) else $error("done not followed by idle");
	a_wr_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_shift |-> $past(cmd.rd_shift)) else $error("shift write without read");
`endif

endmodule

FILE: rtl/core/sorted_key_value_table.sv
// ----------------------------------------------------------------------------
// sorted_key_value_table: 64-entry map kept sorted by a 128-bit key
// Set, lookup, remove and clear over a lower-bound binary search.
// ----------------------------------------------------------------------------
// Usage: drive request and raise start; the request is taken at a clock edge
// where start is high and busy is low. The result appears on result for
// exactly one cycle with done high; the receiver cannot stall and must take
// it then. busy falls in that same cycle, so the next request can be taken
// at the edge that ends the result cycle.
// Sequence: each binary search step is a memory read, then a compare, for
// up to ceil(log2(count+1)) steps, and a final bounds check ends the
// search. Then come the slot read and hit check, a read and a write per
// shifted entry, a final check that ends the shift loop, and the finish
// step; the result shows in the cycle after that. A remove of the first
// entry of a full table is the longest request. The entry memory's
// single registered read port sets this sequence.
// Reset empties the table at once through the entry count; entry contents
// are not cleared, since only entries below the count are ever used.
// ----------------------------------------------------------------------------
module sorted_key_value_table
	import skvt_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  request_t request,
	output logic     done,
	output result_t  result
);

	dp_cmd_t    dp_cmd;
	dp_status_t dp_stat;

	// Sequencer: walks each request through search, shift and completion.
	skvt_controller u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (dp_stat),
		.busy   (busy),
		.cmd    (dp_cmd)
	);

	// Datapath: entry memory, search bounds and the result register.
	skvt_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (request),
		.cmd    (dp_cmd),
		.stat   (dp_stat),
		.done   (done),
		.result (result)
	);

endmodule

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the sorted key/value table
// Drives set, lookup, remove and clear requests through the start/busy
// handshake, keeps its own sorted table to work out each expected result and
// compares every done-marked result field by field in order.
// ----------------------------------------------------------------------------
module tb_top
	import skvt_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS = TABLE_DEPTH;

	logic     clk;
	logic     arst_n;
	logic     start;
	logic     busy;
	request_t request;
	logic     done;
	result_t  result;

	sorted_key_value_table dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.request(request), .done(done), .result(result)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Shadow copy of the table, held sorted by the 128-bit key.
	logic [127:0]       shadow_key [SLOTS];
	logic signed [31:0] shadow_ver [SLOTS];
	logic [31:0]        shadow_name [SLOTS];
	int                 shadow_count;

	result_t expected_results [$];
	int      mismatch_count;
	int      request_count;
	int      full_refusals;
	int      hit_count;

	// Key pool: a small set of keys reused so hits, overwrites and removes
	// happen often. Includes the extremes of both key halves.
	logic [127:0] key_pool [$];

	// Expected result of one request, applied to the shadow table.
	function automatic result_t table_apply(request_t req);
		result_t r;
		logic [127:0] k;
		int lo, hi, mid;
		bit hit;
		k = {req.key_high, req.key_low};
		lo = 0;
		hi = shadow_count;
		while (lo < hi) begin
			mid = lo + (hi - lo) / 2;
			if (shadow_key[mid] < k) lo = mid + 1;
			else hi = mid;
		end
		hit = (lo < shadow_count) && (shadow_key[lo] == k);
		r = '0;
		r.found = hit;
		case (cmd_t'(req.cmd))
			CMD_SET: begin
				if (hit) begin
					shadow_ver[lo] = req.new_version;
					shadow_name[lo] = req.new_name_id;
				end else if (shadow_count >= SLOTS) begin
					r.status = 1'b1;
				end else begin
					for (int i = shadow_count; i > lo; i--) begin
						shadow_key[i] = shadow_key[i-1];
						shadow_ver[i] = shadow_ver[i-1];
						shadow_name[i] = shadow_name[i-1];
					end
					shadow_key[lo] = k;
					shadow_ver[lo] = req.new_version;
					shadow_name[lo] = req.new_name_id;
					shadow_count++;
				end
			end
			CMD_LOOKUP: begin
				r.entry_version = hit ? shadow_ver[lo] : 32'sh8000_0000;
				r.entry_name_id = hit ? shadow_name[lo] : 32'd0;
			end
			CMD_REMOVE: begin
				if (hit) begin
					for (int i = lo; i + 1 < shadow_count; i++) begin
						shadow_key[i] = shadow_key[i+1];
						shadow_ver[i] = shadow_ver[i+1];
						shadow_name[i] = shadow_name[i+1];
					end
					shadow_count--;
				end
			end
			default: shadow_count = 0;
		endcase
		r.entry_count = shadow_count[OUT_CNT_W-1:0];
		return r;
	endfunction

	// Sends one request: raised at a falling edge, taken at the rising edge
	// where busy is low. Start is lowered at the next falling edge.
	task automatic send_request(request_t req);
		@(negedge clk);
		request <= req;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		expected_results.push_back(table_apply(req));
		request_count++;
		if (cmd_t'(req.cmd) == CMD_SET && expected_results[$].status) full_refusals++;
		if (expected_results[$].found) hit_count++;
		@(negedge clk);
		start <= 1'b0;
		// Sender gaps: mostly none, sometimes a short or long pause.
		case ($urandom_range(0, 9))
			0, 1: repeat ($urandom_range(1, 3)) @(negedge clk);
			2: repeat ($urandom_range(4, 20)) @(negedge clk);
			default: ;
		endcase
	endtask

	function automatic request_t make_request(cmd_t c, logic [127:0] k);
		request_t req;
		req.cmd = c;
		{req.key_high, req.key_low} = k;
		req.new_version = $urandom;
		req.new_name_id = $urandom;
		req.new_reserved = $urandom;
		return req;
	endfunction

	function automatic logic [127:0] random_key();
		return {$urandom, $urandom, $urandom, $urandom};
	endfunction

	// Checker: every done pulse is compared with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$error("result with no request outstanding");
				mismatch_count++;
			end else begin
				result_t e;
				e = expected_results.pop_front();
				if (result.found !== e.found) begin
					$error("found: expected %0d actual %0d", e.found, result.found);
					mismatch_count++;
				end
				if (result.entry_version !== e.entry_version) begin
					$error("entry_version: expected %0d actual %0d",
						e.entry_version, result.entry_version);
					mismatch_count++;
				end
				if (result.entry_name_id !== e.entry_name_id) begin
					$error("entry_name_id: expected %0h actual %0h",
						e.entry_name_id, result.entry_name_id);
					mismatch_count++;
				end
				if (result.entry_count !== e.entry_count) begin
					$error("entry_count: expected %0d actual %0d",
						e.entry_count, result.entry_count);
					mismatch_count++;
				end
				if (result.status !== e.status) begin
					$error("status: expected %0d actual %0d", e.status, result.status);
					mismatch_count++;
				end
			end
		end
	end

	// Extremes of the key halves and of the stored fields, every command,
	// lookup and remove of absent keys, and clear reporting a present key.
	task automatic test_directed();
		request_t req;
		logic [127:0] kmax, kmin, kmid;
		kmax = '1;
		kmin = '0;
		kmid = {64'h0, 64'hFFFF_FFFF_FFFF_FFFF};
		send_request(make_request(CMD_LOOKUP, kmin));
		send_request(make_request(CMD_REMOVE, kmax));
		req = make_request(CMD_SET, kmax);
		req.new_version = 32'sh7FFF_FFFF;
		req.new_name_id = '1;
		req.new_reserved = '1;
		send_request(req);
		req = make_request(CMD_SET, kmin);
		req.new_version = 32'sh8000_0000;
		req.new_name_id = '0;
		req.new_reserved = '0;
		send_request(req);
		send_request(make_request(CMD_SET, kmid));
		send_request(make_request(CMD_SET, {64'h1, 64'h0}));
		send_request(make_request(CMD_LOOKUP, kmax));
		send_request(make_request(CMD_LOOKUP, kmin));
		send_request(make_request(CMD_LOOKUP, kmid));
		send_request(make_request(CMD_SET, kmid));
		send_request(make_request(CMD_LOOKUP, kmid));
		send_request(make_request(CMD_LOOKUP, {64'h1, 64'h1}));
		send_request(make_request(CMD_REMOVE, kmin));
		send_request(make_request(CMD_REMOVE, kmin));
		send_request(make_request(CMD_LOOKUP, kmin));
		send_request(make_request(CMD_CLEAR, kmax));
		send_request(make_request(CMD_LOOKUP, kmax));
		send_request(make_request(CMD_CLEAR, kmax));
	endtask

	// Fills the table to capacity, has new keys refused, overwrites and
	// removes at both ends while full, then clears.
	task automatic test_full_table();
		logic [127:0] k;
		for (int i = 0; i < SLOTS; i++) begin
			k = random_key();
			key_pool.push_back(k);
			send_request(make_request(CMD_SET, k));
		end
		send_request(make_request(CMD_SET, '1));
		send_request(make_request(CMD_SET, '0));
		send_request(make_request(CMD_SET, random_key()));
		send_request(make_request(CMD_SET, key_pool[3]));
		send_request(make_request(CMD_LOOKUP, key_pool[3]));
		send_request(make_request(CMD_REMOVE, shadow_key[0]));
		send_request(make_request(CMD_SET, '0));
		send_request(make_request(CMD_REMOVE, shadow_key[SLOTS-1]));
		send_request(make_request(CMD_SET, '1));
		send_request(make_request(CMD_LOOKUP, '1));
		send_request(make_request(CMD_CLEAR, key_pool[5]));
	endtask

	// Random mix over a bounded key pool so the table stays busy with hits;
	// a few fully random keys and rare clears add noise.
	task automatic test_random_mix(int n);
		logic [127:0] k;
		cmd_t c;
		int pick;
		key_pool = {};
		for (int i = 0; i < 80; i++) key_pool.push_back(random_key());
		key_pool.push_back('0);
		key_pool.push_back('1);
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) c = CMD_SET;
			else if (pick < 75) c = CMD_LOOKUP;
			else if (pick < 98) c = CMD_REMOVE;
			else c = CMD_CLEAR;
			if ($urandom_range(0, 9) == 0) k = random_key();
			else k = key_pool[$urandom_range(0, key_pool.size() - 1)];
			send_request(make_request(c, k));
		end
	endtask

	initial begin
		start = 1'b0;
		request = '0;
		arst_n = 1'b0;
		shadow_count = 0;
		mismatch_count = 0;
		request_count = 0;
		full_refusals = 0;
		hit_count = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_full_table();
		test_random_mix(650);

		while (expected_results.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);

		$display("Ran %0d requests: %0d found an existing key, %0d sets refused on a full table.",
			request_count, hit_count, full_refusals);
		if (mismatch_count == 0 && expected_results.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// The time limit covers the longest request plus sender gaps; allow plenty.
	initial begin
		#20ms;
		$display("end of test: mismatches");
		$finish;
	end
endmodule
